>>> src/sse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    // Element width, used by the word formats below
    localparam int DATA_W = 32;

    // Input word: one element of a set
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } sse_in_t;

    // Result word: one sorted element
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflowed;
    } sse_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } sse_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic issue_rd;
        logic emit;
    } sse_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_at_end;
        logic pass_last;
        logic out_free;
    } sse_status_t;

endpackage

`default_nettype wire

>>> src/sse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_is_last,
    output logic                     s_ready,
    input  wire sse_pkg::sse_status_t status,
    output sse_pkg::sse_cmd_t        cmd
);

    sse_pkg::sse_state_t state_reg;
    sse_pkg::sse_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sse_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            sse_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_is_last) begin
                    state_next = sse_pkg::ST_SCAN;
                end
            end
            sse_pkg::ST_SCAN: begin
                // issue one buffer read per cycle up to the last held entry
                cmd.issue_rd = 1'b1;
                if (status.scan_at_end) begin
                    state_next = sse_pkg::ST_DRAIN;
                end
            end
            sse_pkg::ST_DRAIN: begin
                // last read data is compared in this cycle
                state_next = sse_pkg::ST_EMIT;
            end
            sse_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.pass_last) begin
                        state_next = sse_pkg::ST_LOAD;
                    end else begin
                        state_next = sse_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = sse_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/sse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sse_datapath #(
    parameter int DEPTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sse_pkg::sse_in_t     s_data,
    input  wire sse_pkg::sse_cmd_t    cmd,
    output sse_pkg::sse_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sse_pkg::sse_out_t         m_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Element buffer
    logic [sse_pkg::DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] pass_reg, pass_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] last_idx;

    logic                              rd_vld_reg;
    logic [IDX_W-1:0]                  rd_tag_reg;
    logic signed [sse_pkg::DATA_W-1:0] rd_data_reg;

    logic signed [sse_pkg::DATA_W-1:0] min_val_reg;
    logic [IDX_W-1:0]                  min_idx_reg;
    logic [sse_pkg::DATA_W-1:0]        first_val_reg;

    logic                 m_valid_reg, m_valid_next;
    sse_pkg::sse_out_t    m_word_reg;

    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [sse_pkg::DATA_W-1:0] wr_data;
    logic                       room;

    assign room     = (count_reg < CNT_W'(DEPTH));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    assign status.scan_at_end = (scan_reg == last_idx);
    assign status.pass_last   = (pass_reg == last_idx);
    assign status.out_free    = !m_valid_reg || m_ready;

    // Select the buffer write: incoming element or the displaced entry of a pass
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = s_data.value;
        if (cmd.load && room) begin
            wr_en = 1'b1;
        end else if (cmd.emit) begin
            wr_en   = 1'b1;
            wr_addr = min_idx_reg;
            wr_data = first_val_reg;
        end
    end

    // Buffer write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[scan_reg];
        rd_tag_reg  <= scan_reg;
    end

    // Fill count, overflow flag and pass counters
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pass_next  = pass_reg;
        scan_next  = scan_reg;
        if (cmd.load) begin
            if (room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.issue_rd && !status.scan_at_end) begin
            scan_next = scan_reg + IDX_W'(1);
        end
        if (cmd.emit) begin
            if (status.pass_last) begin
                count_next = '0;
                ovf_next   = 1'b0;
                pass_next  = '0;
                scan_next  = '0;
            end else begin
                pass_next = pass_reg + IDX_W'(1);
                scan_next = pass_reg + IDX_W'(1);
            end
        end
    end

    // Output valid: set on emit, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            pass_reg    <= '0;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pass_reg    <= pass_next;
            scan_reg    <= scan_next;
            rd_vld_reg  <= cmd.issue_rd;
            m_valid_reg <= m_valid_next;
        end
    end

    // Track the first smallest entry of the current pass
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            if (rd_tag_reg == pass_reg) begin
                min_val_reg   <= rd_data_reg;
                min_idx_reg   <= rd_tag_reg;
                first_val_reg <= rd_data_reg;
            end else if (min_val_reg > rd_data_reg) begin
                min_val_reg <= rd_data_reg;
                min_idx_reg <= rd_tag_reg;
            end
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_word_reg.sorted_value <= min_val_reg;
            m_word_reg.last_out     <= status.pass_last;
            m_word_reg.overflowed   <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    // Never overwrite a result word that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten");

    // Fill count stays within the buffer
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // Final pass empties the buffer for the next set
    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.pass_last) |=> (count_reg == '0 && !ovf_reg))
        else $error("buffer not emptied after set");

    // Scan never reads past the held entries nor behind the pass start
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_rd |-> (scan_reg <= last_idx && scan_reg >= pass_reg))
        else $error("scan address out of range");

endmodule

`default_nettype wire

>>> src/selection_sort_engine_core.sv
// Load: one input word per cycle while in the load state; a word beyond DEPTH entries
// is dropped, and no input is taken while a set is sorted. Sort of n held entries:
// pass i scans entries i to n-1, one buffer read per cycle, then emits one result word.
// Output stalls hold back the emit of a result word and so delay the next pass.
// Reset (aresetn low, synchronous) clears the sequencer, fill count, overflow flag
// and output valid; buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module selection_sort_engine_core #(
    parameter int DEPTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sse_pkg::sse_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sse_pkg::sse_out_t      m_data
);

    sse_pkg::sse_cmd_t    cmd;
    sse_pkg::sse_status_t status;

    sse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_data.is_last),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_selection_sort_engine_core.sv
`timescale 1ns / 1ps

module tb_selection_sort_engine_core;

    localparam int          SORT_DEPTH  = 32;
    localparam int          RAND_WORDS  = 104;
    localparam int          DRAIN_TAIL  = 64;
    localparam int          LONG_HOLD   = 300;
    localparam int          MAX_REPORTS = 10;
    localparam longint      RUN_LIMIT   = 64'd5_000_000;

    typedef logic signed [sse_pkg::DATA_W-1:0] elem_t;

    // Track sets as they are loaded and predict the sorted output words
    class sort_scoreboard;
        elem_t             held[SORT_DEPTH];
        int unsigned       held_count;
        bit                dropped_any;
        sse_pkg::sse_out_t sorted_q[$];
        int unsigned       mismatches;

        function new();
            held_count  = 0;
            dropped_any = 1'b0;
            mismatches  = 0;
        endfunction

        // Store one accepted element; on the closing word sort and queue the set
        function void note_word(sse_pkg::sse_in_t w);
            elem_t             tmp;
            int unsigned       pick;
            sse_pkg::sse_out_t r;
            if (held_count < SORT_DEPTH) begin
                held[held_count] = w.value;
                held_count++;
            end else begin
                dropped_any = 1'b1;
            end
            if (!w.is_last)
                return;
            // Selection sort, first smallest wins on ties
            for (int unsigned i = 0; i + 1 < held_count; i++) begin
                pick = i;
                for (int unsigned j = i + 1; j < held_count; j++) begin
                    if (held[pick] > held[j])
                        pick = j;
                end
                if (pick != i) begin
                    tmp        = held[pick];
                    held[pick] = held[i];
                    held[i]    = tmp;
                end
            end
            for (int unsigned k = 0; k < held_count; k++) begin
                r.sorted_value = held[k];
                r.last_out     = (k + 1 == held_count);
                r.overflowed   = dropped_any;
                sorted_q.push_back(r);
            end
            held_count  = 0;
            dropped_any = 1'b0;
        endfunction

        // Compare one result word against the oldest prediction
        function void check_word(sse_pkg::sse_out_t got);
            sse_pkg::sse_out_t want;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word value=%0d last=%0b ovf=%0b", $realtime,
                             got.sorted_value, got.last_out, got.overflowed);
                return;
            end
            want = sorted_q.pop_front();
            if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out ||
                got.overflowed !== want.overflowed) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: mismatch value exp=%0d got=%0d",
                              " last exp=%0b got=%0b ovf exp=%0b got=%0b"},
                             $realtime, want.sorted_value, got.sorted_value,
                             want.last_out, got.last_out, want.overflowed, got.overflowed);
            end
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sse_pkg::sse_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sse_pkg::sse_out_t m_data;

    sort_scoreboard sb = new();
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;
    int unsigned hold_req  = 0;
    int unsigned rand_sent = 0;

    selection_sort_engine_core #(.DEPTH(SORT_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Draw the sender gap; switch now and then into a run with no gaps
    function automatic int unsigned draw_tx_gap();
        if ($urandom_range(0, 11) == 0)
            tx_calm = ~tx_calm;
        return tx_calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Draw the receiver stall the same way
    function automatic int unsigned draw_rx_stall();
        if ($urandom_range(0, 11) == 0)
            rx_calm = ~rx_calm;
        return rx_calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Mix tiny values (many ties), extremes and full-range values
    function automatic elem_t pick_value();
        int v;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 4);
                return elem_t'(v - 2);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return elem_t'($urandom);
        endcase
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input elem_t val, input logic last);
        int unsigned      gap;
        sse_pkg::sse_in_t w;
        gap = draw_tx_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        w.value   = val;
        w.is_last = last;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    // Send a set of random elements, closing it on the final word
    task automatic send_set(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_word(pick_value(), i + 1 == n);
            rand_sent++;
        end
    endtask

    // Send a fixed set given as a list
    task automatic send_list(input elem_t vals[$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
    endtask

    // Pick a set size: mostly short, sometimes full or overflowing
    function automatic int unsigned pick_set_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 82)
            return $urandom_range(9, SORT_DEPTH - 1);
        if (r < 91)
            return SORT_DEPTH;
        return $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 6);
    endfunction

    // Receiver: draw a stall after each word taken, or hold off for a long stretch on request
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                stall    = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (m_valid && m_ready) begin
                stall = draw_rx_stall();
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_data);
    end

    // Stimulus
    initial begin
        int unsigned set_len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-element sets at both extremes
        send_list('{32'h7FFF_FFFF});
        send_list('{32'h8000_0000});
        // Mixed signs and extremes
        send_list('{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_0001});
        // Ties among equal values
        send_list('{32'sd5, -32'sd3, 32'sd5, -32'sd3, 32'sd5});
        // Already descending
        send_list('{32'sd3, 32'sd2, 32'sd1, 32'sd0});

        // Fill the block while the receiver holds off
        send_set(6);
        hold_req = LONG_HOLD;
        send_set(12);

        // Guarantee a full set and an overflowing set
        send_set(SORT_DEPTH);
        send_set(SORT_DEPTH + 3);
        // Trim the last random set so the total stays on target
        while (rand_sent < RAND_WORDS) begin
            set_len = pick_set_size();
            if (set_len > RAND_WORDS - rand_sent)
                set_len = RAND_WORDS - rand_sent;
            send_set(set_len);
        end

        s_valid <= 1'b0;
        while (sb.sorted_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (sb.mismatches == 0 && sb.sorted_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
src/sse_pkg.sv
src/sse_ctrl.sv
src/sse_datapath.sv
src/selection_sort_engine_core.sv
bench/tb_selection_sort_engine_core.sv
